/* sv/ctbt_pkg.sv */
// Shared types, constants and the microprogram of the tree traversal block.
// No dependencies; used by ctbt_seq, ctbt_dp and complete_binary_tree_traversal.
package ctbt_pkg;

    localparam int CAPACITY = 32;
    localparam int CHAR_W   = 8;
    localparam int STEP_W   = 5;

    typedef struct packed {
        logic              op;
        logic [CHAR_W-1:0] char_value;
        logic [1:0]        walk_order;
    } t_in_item;

    typedef struct packed {
        logic              kind;
        logic              status;
        logic [CHAR_W-1:0] node_char;
        logic              last;
    } t_out_item;

    localparam logic OP_LOAD     = 1'b0;
    localparam logic OP_TRAVERSE = 1'b1;

    localparam logic [1:0] ORD_IN     = 2'd0;
    localparam logic [1:0] ORD_PRE    = 2'd1;
    localparam logic [1:0] ORD_POST   = 2'd2;
    // Walk order with no meaning; a traverse request with it answers nothing.
    localparam logic [1:0] ORD_UNUSED = 2'd3;

    localparam logic KIND_ACK  = 1'b0;
    localparam logic KIND_CHAR = 1'b1;

    localparam logic ST_STORED  = 1'b0;
    localparam logic ST_DROPPED = 1'b1;

    // Datapath operations on the node number register.
    typedef enum logic [2:0] {
        DP_NOP,
        DP_DBL,    // i = 2i
        DP_DBL1,   // i = 2i + 1
        DP_HALF,   // i = i / 2
        DP_INC,    // i = i + 1
        DP_ZERO    // i = 0, walk finished
    } t_dp_op;

    // Branch conditions.
    typedef enum logic [3:0] {
        C_ALWAYS,
        C_ORD0,
        C_ORD1,
        C_LEFT,      // 2i <= n
        C_RIGHT,     // 2i + 1 <= n
        C_LE1,       // i <= 1
        C_EVEN_SIB,  // i even and i + 1 <= n
        C_ODD_GT1,   // i odd and i > 1
        C_PUP,       // i > 1 and (i odd or i + 1 > n)
        C_GT1,       // i > 1
        C_NZ         // i != 0
    } t_cond;

    // Flags from the datapath, sampled by the sequencer.
    typedef struct packed {
        logic left;
        logic right;
        logic le1;
        logic even_sib;
        logic odd_gt1;
        logic pup;
        logic gt1;
        logic nz;
    } t_flags;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        t_dp_op op;
        logic   rd;
        logic   emit;
    } t_ctrl;

    // One microinstruction: when cond holds, apply op and jump to tgt;
    // otherwise fall through. rd and emit act whatever the condition.
    typedef struct packed {
        t_cond             cond;
        t_dp_op            op;
        logic [STEP_W-1:0] tgt;
        logic              rd;
        logic              emit;
        logic              done;
    } t_uword;

    localparam logic [STEP_W-1:0] S_ENTRY = STEP_W'(0);
    localparam logic [STEP_W-1:0] S_FDL   = STEP_W'(1);
    localparam logic [STEP_W-1:0] S_VISIT = STEP_W'(2);
    localparam logic [STEP_W-1:0] S_POST  = STEP_W'(4);
    localparam logic [STEP_W-1:0] S_DL    = STEP_W'(7);
    localparam logic [STEP_W-1:0] S_EMIT  = STEP_W'(8);
    localparam logic [STEP_W-1:0] S_DONE  = STEP_W'(9);
    localparam logic [STEP_W-1:0] S_IN    = STEP_W'(10);
    localparam logic [STEP_W-1:0] S_INUP  = STEP_W'(11);
    localparam logic [STEP_W-1:0] S_PRE   = STEP_W'(13);
    localparam logic [STEP_W-1:0] S_PREUP = STEP_W'(14);

    function automatic t_uword uw(t_cond c, t_dp_op o, logic [STEP_W-1:0] t,
                                  logic rd, logic emit, logic done);
        t_uword w;
        w.cond = c;
        w.op   = o;
        w.tgt  = t;
        w.rd   = rd;
        w.emit = emit;
        w.done = done;
        return w;
    endfunction

    // Microprogram: each visit reads the node, computes the successor,
    // then emits the node with last set when the successor is zero.
    function automatic t_uword rom_word(logic [STEP_W-1:0] step);
        t_uword w;
        case (step)
            5'd0:    w = uw(C_ORD1,     DP_NOP,  S_VISIT, 1'b0, 1'b0, 1'b0);
            5'd1:    w = uw(C_LEFT,     DP_DBL,  S_FDL,   1'b0, 1'b0, 1'b0);
            5'd2:    w = uw(C_ORD1,     DP_NOP,  S_PRE,   1'b1, 1'b0, 1'b0);
            5'd3:    w = uw(C_ORD0,     DP_NOP,  S_IN,    1'b0, 1'b0, 1'b0);
            5'd4:    w = uw(C_LE1,      DP_ZERO, S_EMIT,  1'b0, 1'b0, 1'b0);
            5'd5:    w = uw(C_EVEN_SIB, DP_INC,  S_DL,    1'b0, 1'b0, 1'b0);
            5'd6:    w = uw(C_ALWAYS,   DP_HALF, S_EMIT,  1'b0, 1'b0, 1'b0);
            5'd7:    w = uw(C_LEFT,     DP_DBL,  S_DL,    1'b0, 1'b0, 1'b0);
            5'd8:    w = uw(C_NZ,       DP_NOP,  S_VISIT, 1'b0, 1'b1, 1'b0);
            5'd9:    w = uw(C_ALWAYS,   DP_NOP,  S_DONE,  1'b0, 1'b0, 1'b1);
            5'd10:   w = uw(C_RIGHT,    DP_DBL1, S_DL,    1'b0, 1'b0, 1'b0);
            5'd11:   w = uw(C_ODD_GT1,  DP_HALF, S_INUP,  1'b0, 1'b0, 1'b0);
            5'd12:   w = uw(C_ALWAYS,   DP_HALF, S_EMIT,  1'b0, 1'b0, 1'b0);
            5'd13:   w = uw(C_LEFT,     DP_DBL,  S_EMIT,  1'b0, 1'b0, 1'b0);
            5'd14:   w = uw(C_PUP,      DP_HALF, S_PREUP, 1'b0, 1'b0, 1'b0);
            5'd15:   w = uw(C_GT1,      DP_INC,  S_EMIT,  1'b0, 1'b0, 1'b0);
            5'd16:   w = uw(C_ALWAYS,   DP_ZERO, S_EMIT,  1'b0, 1'b0, 1'b0);
            default: w = uw(C_ALWAYS,   DP_NOP,  S_DONE,  1'b0, 1'b0, 1'b1);
        endcase
        return w;
    endfunction

endpackage

/* sv/ctbt_seq.sv */
// Microcode sequencer: step counter, program table and branch logic.
// Depends on ctbt_pkg.
module ctbt_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  logic [1:0]        i_order,
    input  ctbt_pkg::t_flags  i_flags,
    output ctbt_pkg::t_ctrl   o_ctrl,
    output logic              o_run
);

    logic [ctbt_pkg::STEP_W-1:0] r_step, n_step;
    logic                        r_run, n_run;
    logic [1:0]                  r_order, n_order;
    ctbt_pkg::t_uword            w;
    logic                        take;

    always_comb begin
        w = ctbt_pkg::rom_word(r_step);
        case (w.cond)
            ctbt_pkg::C_ALWAYS:   take = 1'b1;
            ctbt_pkg::C_ORD0:     take = (r_order == ctbt_pkg::ORD_IN);
            ctbt_pkg::C_ORD1:     take = (r_order == ctbt_pkg::ORD_PRE);
            ctbt_pkg::C_LEFT:     take = i_flags.left;
            ctbt_pkg::C_RIGHT:    take = i_flags.right;
            ctbt_pkg::C_LE1:      take = i_flags.le1;
            ctbt_pkg::C_EVEN_SIB: take = i_flags.even_sib;
            ctbt_pkg::C_ODD_GT1:  take = i_flags.odd_gt1;
            ctbt_pkg::C_PUP:      take = i_flags.pup;
            ctbt_pkg::C_GT1:      take = i_flags.gt1;
            ctbt_pkg::C_NZ:       take = i_flags.nz;
            default:              take = 1'b0;
        endcase
    end

    always_comb begin
        o_ctrl.op   = (r_run && take) ? w.op : ctbt_pkg::DP_NOP;
        o_ctrl.rd   = r_run && w.rd;
        o_ctrl.emit = r_run && w.emit;
        o_run       = r_run;

        n_step  = r_step;
        n_run   = r_run;
        n_order = r_order;
        if (i_go) begin
            n_run   = 1'b1;
            n_step  = ctbt_pkg::S_ENTRY;
            n_order = i_order;
        end else if (r_run) begin
            if (w.done) begin
                n_run = 1'b0;
            end else if (take) begin
                n_step = w.tgt;
            end else begin
                n_step = r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_step <= ctbt_pkg::S_ENTRY;
        end else begin
            r_run  <= n_run;
            r_step <= n_step;
        end
        r_order <= n_order;
    end

endmodule

/* sv/ctbt_dp.sv */
// Datapath: node number register, node count, character store and result register.
// Depends on ctbt_pkg.
module ctbt_dp #(
    parameter int CAPACITY = ctbt_pkg::CAPACITY
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  logic                i_go,
    input  logic [ctbt_pkg::CHAR_W-1:0] i_char,
    input  ctbt_pkg::t_ctrl     i_ctrl,
    output ctbt_pkg::t_flags    o_flags,
    output logic                o_empty,
    output logic                o_res_valid,
    output ctbt_pkg::t_out_item o_res
);

    localparam int NW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic [ctbt_pkg::CHAR_W-1:0] mem [CAPACITY];

    logic [NW-1:0]               r_node, n_node;
    logic [NW-1:0]               r_count;
    logic [ctbt_pkg::CHAR_W-1:0] r_rdata;
    logic                        r_res_valid;
    ctbt_pkg::t_out_item         r_res;

    logic [NW:0] node_x, count_x, twice, twice1, plus1;
    logic        full;
    logic [NW-1:0] rd_node;

    always_comb begin
        node_x  = {1'b0, r_node};
        count_x = {1'b0, r_count};
        twice   = {r_node, 1'b0};
        twice1  = {r_node, 1'b1};
        plus1   = node_x + 1'b1;

        o_flags.left     = (twice  <= count_x);
        o_flags.right    = (twice1 <= count_x);
        o_flags.le1      = (r_node <= NW'(1));
        o_flags.gt1      = !o_flags.le1;
        o_flags.even_sib = !r_node[0] && (plus1 <= count_x);
        o_flags.odd_gt1  = r_node[0] && o_flags.gt1;
        o_flags.pup      = o_flags.gt1 && (r_node[0] || (plus1 > count_x));
        o_flags.nz       = (r_node != '0);

        full    = (r_count == NW'(CAPACITY));
        o_empty = (r_count == '0);
        rd_node = r_node - 1'b1;

        case (i_ctrl.op)
            ctbt_pkg::DP_NOP:  n_node = r_node;
            ctbt_pkg::DP_DBL:  n_node = twice[NW-1:0];
            ctbt_pkg::DP_DBL1: n_node = twice1[NW-1:0];
            ctbt_pkg::DP_HALF: n_node = r_node >> 1;
            ctbt_pkg::DP_INC:  n_node = plus1[NW-1:0];
            ctbt_pkg::DP_ZERO: n_node = '0;
            default:           n_node = r_node;
        endcase
        if (i_go) begin
            n_node = NW'(1);
        end
    end

    // Store write on load, registered read on visit.
    always_ff @(posedge i_clk) begin
        if (i_load && !full) begin
            mem[r_count[AW-1:0]] <= i_char;
        end
        if (i_ctrl.rd) begin
            r_rdata <= mem[rd_node[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= i_load || i_ctrl.emit;
            if (i_load && !full) begin
                r_count <= r_count + 1'b1;
            end
        end
        r_node <= n_node;
        if (i_load) begin
            r_res.kind      <= ctbt_pkg::KIND_ACK;
            r_res.status    <= full ? ctbt_pkg::ST_DROPPED : ctbt_pkg::ST_STORED;
            r_res.node_char <= '0;
            r_res.last      <= 1'b1;
        end else begin
            r_res.kind      <= ctbt_pkg::KIND_CHAR;
            r_res.status    <= ctbt_pkg::ST_STORED;
            r_res.node_char <= r_rdata;
            r_res.last      <= !o_flags.nz;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

/* sv/complete_binary_tree_traversal.sv */
// Top level of the complete binary tree traversal block.
// Depends on ctbt_pkg, ctbt_seq and ctbt_dp.
//
// Usage: raise start with a request on i_req while busy is low. A load
// request appends one character in level order and answers one
// acknowledgement in the next cycle (status set when the store was full and
// the character was dropped); busy stays low, so loads can follow every
// cycle. A traverse request raises busy and emits one character per stored
// node in the chosen order, the final one marked by last. Each visit is
// walked by the microprogram, which steps the node number up or down by at
// most one tree level per cycle. A traverse of an empty tree or with order
// 3 answers nothing and leaves busy low. Results appear for exactly one
// cycle on o_res with o_res_valid high; the receiver cannot stall them,
// so it must take every strobe.
module complete_binary_tree_traversal #(
    parameter int CAPACITY = ctbt_pkg::CAPACITY
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  ctbt_pkg::t_in_item  i_req,
    output logic                busy,
    output logic                o_res_valid,
    output ctbt_pkg::t_out_item o_res
);

    ctbt_pkg::t_flags flags;
    ctbt_pkg::t_ctrl  ctrl;
    logic             run;
    logic             empty;
    logic             accept;
    logic             load;
    logic             go;

    // Decode the accepted request: load goes straight to the datapath, a
    // valid traversal of a non-empty tree starts the microprogram.
    assign accept = start && !busy;
    assign load   = accept && (i_req.op == ctbt_pkg::OP_LOAD);
    assign go     = accept && (i_req.op == ctbt_pkg::OP_TRAVERSE) && !empty
                    && (i_req.walk_order != ctbt_pkg::ORD_UNUSED);
    assign busy   = run;

    ctbt_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_order (i_req.walk_order),
        .i_flags (flags),
        .o_ctrl  (ctrl),
        .o_run   (run)
    );

    ctbt_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_go        (go),
        .i_char      (i_req.char_value),
        .i_ctrl      (ctrl),
        .o_flags     (flags),
        .o_empty     (empty),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

endmodule

/* dv/tb.sv */
// Self-checking bench for complete_binary_tree_traversal: loads characters, walks the tree.
// Depends on ctbt_pkg and the RTL; predicts acks and visit order with its own tree copy.
module tb;

    localparam int CW = ctbt_pkg::CHAR_W;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 40;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    ctbt_pkg::t_in_item  i_req;
    logic                busy;
    logic                o_res_valid;
    ctbt_pkg::t_out_item o_res;

    // Predictor state: characters in level order and how many are stored.
    logic [CW-1:0] tree_chars [ctbt_pkg::CAPACITY];
    int unsigned   tree_size;

    // Acks and visited characters still owed by the block, oldest first.
    ctbt_pkg::t_out_item answer_q [$];

    int errors;
    int cycles;
    int results_seen;
    int loads_taken;
    int walks_taken;
    int loads_sent;
    bit idle_mode;

    complete_binary_tree_traversal u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_req       (i_req),
        .busy        (busy),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

    always #10 i_clk = ~i_clk;

    // Descend through left children (right never comes first) to the deepest node.
    function automatic int unsigned leftmost_leaf(int unsigned node, int unsigned n);
        while (2 * node <= n)
            node = 2 * node;
        return node;
    endfunction

    // Next node number in the given order, 0 once the walk is over.
    function automatic int unsigned next_visit(logic [1:0] order, int unsigned node,
                                               int unsigned n);
        case (order)
            ctbt_pkg::ORD_IN: begin
                if (2 * node + 1 <= n)
                    return leftmost_leaf(2 * node + 1, n);
                // climb while we are a right child, then the parent is next
                while (node > 1 && node[0])
                    node = node >> 1;
                return node >> 1;
            end
            ctbt_pkg::ORD_PRE: begin
                if (2 * node <= n)
                    return 2 * node;
                // climb until a left child with a right sibling is found
                while (node > 1 && (node[0] || node + 1 > n))
                    node = node >> 1;
                return (node > 1) ? node + 1 : 0;
            end
            default: begin
                if (node <= 1)
                    return 0;
                if (!node[0] && node + 1 <= n)
                    return leftmost_leaf(node + 1, n);
                return node >> 1;
            end
        endcase
    endfunction

    // Work out everything one accepted request owes and queue it.
    function automatic void tree_answers(ctbt_pkg::t_in_item req);
        ctbt_pkg::t_out_item ans;
        int unsigned         node;
        int unsigned         nxt;
        int                  k;
        if (req.op == ctbt_pkg::OP_LOAD) begin
            ans.kind      = ctbt_pkg::KIND_ACK;
            ans.node_char = '0;
            ans.last      = 1'b1;
            if (tree_size < ctbt_pkg::CAPACITY) begin
                tree_chars[tree_size] = req.char_value;
                tree_size++;
                ans.status = ctbt_pkg::ST_STORED;
            end else begin
                ans.status = ctbt_pkg::ST_DROPPED;
            end
            answer_q.push_back(ans);
            loads_taken++;
            return;
        end
        walks_taken++;
        // empty tree or unused order: nothing comes back
        if (req.walk_order == ctbt_pkg::ORD_UNUSED || tree_size == 0)
            return;
        node = (req.walk_order == ctbt_pkg::ORD_PRE) ? 1 : leftmost_leaf(1, tree_size);
        k = 0;
        while (node != 0 && k < ctbt_pkg::CAPACITY) begin
            nxt           = next_visit(req.walk_order, node, tree_size);
            ans.kind      = ctbt_pkg::KIND_CHAR;
            ans.status    = ctbt_pkg::ST_STORED;
            ans.node_char = tree_chars[node - 1];
            ans.last      = (nxt == 0 || k + 1 >= ctbt_pkg::CAPACITY);
            answer_q.push_back(ans);
            k++;
            node = nxt;
        end
    endfunction

    function automatic void check_answer(ctbt_pkg::t_out_item got);
        ctbt_pkg::t_out_item want;
        results_seen++;
        if (answer_q.size() == 0) begin
            $error("result with nothing pending: kind %0d char %0h",
                   got.kind, got.node_char);
            errors++;
            return;
        end
        want = answer_q.pop_front();
        if (got.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, got.kind);
            errors++;
        end
        if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
        end
        if (got.node_char !== want.node_char) begin
            $error("node_char: expected %0h, got %0h", want.node_char, got.node_char);
            errors++;
        end
        if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            errors++;
        end
    endfunction

    // Record each accepted request before checking, so ordering within the edge is fixed.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                tree_answers(i_req);
            if (o_res_valid)
                check_answer(o_res);
        end
    end

    // Watchdog: a hung block must not keep the run alive.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles, answer_q.size());
            $display("status: fail");
            $finish;
        end
    end

    function automatic ctbt_pkg::t_in_item make_req(logic op, logic [CW-1:0] ch,
                                                    logic [1:0] ord);
        ctbt_pkg::t_in_item r;
        r.op         = op;
        r.char_value = ch;
        r.walk_order = ord;
        return r;
    endfunction

    // Raise start with the request, hold until the block takes it, then maybe idle.
    task automatic send_request(ctbt_pkg::t_in_item req);
        int gap;
        i_req <= req;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        if (req.op == ctbt_pkg::OP_LOAD)
            loads_sent++;
        gap = idle_mode ? $urandom_range(0, 7) : 0;
        // switch between back-to-back stretches and idling stretches now and then
        if ($urandom_range(0, 7) == 0)
            idle_mode = !idle_mode;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_load(logic [CW-1:0] ch);
        send_request(make_req(ctbt_pkg::OP_LOAD, ch, 2'($urandom_range(0, 3))));
    endtask

    task automatic send_walk(logic [1:0] ord);
        send_request(make_req(ctbt_pkg::OP_TRAVERSE, CW'($urandom), ord));
    endtask

    // Walks of an empty tree, every order plus the unused one: all silent.
    task automatic test_empty_tree();
        send_walk(ctbt_pkg::ORD_IN);
        send_walk(ctbt_pkg::ORD_PRE);
        send_walk(ctbt_pkg::ORD_POST);
        send_walk(ctbt_pkg::ORD_UNUSED);
    endtask

    // Tiny trees where the three orders are easy to tell apart.
    task automatic test_small_trees();
        send_request(make_req(ctbt_pkg::OP_LOAD, 8'h00, ctbt_pkg::ORD_UNUSED));
        send_walk(ctbt_pkg::ORD_IN);
        send_walk(ctbt_pkg::ORD_PRE);
        send_walk(ctbt_pkg::ORD_POST);
        send_request(make_req(ctbt_pkg::OP_LOAD, 8'hFF, ctbt_pkg::ORD_IN));
        send_walk(ctbt_pkg::ORD_PRE);
        send_walk(ctbt_pkg::ORD_POST);
        send_load(8'h5A);
        send_load(8'hA5);
        send_walk(ctbt_pkg::ORD_IN);
        send_walk(ctbt_pkg::ORD_PRE);
        send_walk(ctbt_pkg::ORD_POST);
        send_walk(ctbt_pkg::ORD_UNUSED);
    endtask

    // Grow the tree with random characters, walking it at many sizes, then keep
    // walking the full tree with the odd dropped load mixed in.
    task automatic test_random_mix(int count);
        int  pick;
        logic [1:0] ord;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if ((loads_sent < ctbt_pkg::CAPACITY && pick < 55) || pick < 20) begin
                send_load(CW'($urandom));
            end else begin
                ord = ($urandom_range(0, 9) == 0) ? ctbt_pkg::ORD_UNUSED
                                                  : 2'($urandom_range(0, 2));
                send_walk(ord);
            end
        end
    endtask

    // Top up to capacity, then drop loads and walk the full tree in every order.
    task automatic test_store_full();
        while (loads_sent < ctbt_pkg::CAPACITY)
            send_load(CW'($urandom));
        send_load(8'hFF);
        send_load(8'h00);
        send_walk(ctbt_pkg::ORD_IN);
        send_walk(ctbt_pkg::ORD_PRE);
        send_walk(ctbt_pkg::ORD_POST);
        send_walk(ctbt_pkg::ORD_UNUSED);
    endtask

    initial begin
        i_clk      = 1'b0;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_req      = '0;
        tree_size  = 0;
        errors     = 0;
        cycles     = 0;
        idle_mode  = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_tree();
        test_small_trees();
        test_random_mix(100);
        test_store_full();

        start <= 1'b0;
        @(posedge i_clk);
        // drain: wait out every owed result, then watch for strays
        while (answer_q.size() != 0 || busy)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("ran %0d loads and %0d walks, tree grew to %0d of %0d nodes",
                 loads_taken, walks_taken, tree_size, ctbt_pkg::CAPACITY);
        $display("checked %0d results with %0d mismatches in %0d cycles",
                 results_seen, errors, cycles);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
